### rtl/stick_angle_spinner_core_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef STICK_ANGLE_SPINNER_CORE_MACROS_SVH
`define STICK_ANGLE_SPINNER_CORE_MACROS_SVH

// same-cycle implication
`define SAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sas_pkg.sv
package sas_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_ZONE_LOW  = 2'd0;
   localparam logic [1:0] CSR_ZONE_HIGH = 2'd1;
   localparam logic [1:0] CSR_MAX_STEP  = 2'd2;

   localparam logic [7:0] ZONE_LOW_RST  = 8'd64;
   localparam logic [7:0] ZONE_HIGH_RST = 8'd192;
   localparam logic [6:0] MAX_STEP_RST  = 7'd16;

   localparam logic [7:0] BYTE_CENTRE = 8'h80;

   // tangent table, scaled by 10^9
   localparam int unsigned TAN_W = 30;
   localparam logic [TAN_W-1:0] TAN_ONE = 30'd1000000000;
   localparam logic [5:0] TAN_LAST   = 6'd44;
   localparam logic [5:0] OCT_EQUAL  = 6'd45;

   localparam logic [6:0] DEG_90     = 7'd90;
   localparam logic [7:0] DEG_180    = 8'd180;
   localparam logic [8:0] ANG_OFFSET = 9'd179;
   localparam logic [8:0] ANG_MAX    = 9'd359;

   typedef struct packed {
      logic              start;
      logic signed [7:0] x;
      logic signed [7:0] y;
   } sas_ang_req_type;

   typedef struct packed {
      logic       done;
      logic [8:0] angle;
   } sas_ang_rsp_type;

   // tan(k deg) * 10^9 for k = 1..44
   function automatic logic [TAN_W-1:0] tan_e9(logic [5:0] k);
      logic [TAN_W-1:0] t;
      unique case (k)
         6'd1:  t = 30'd17455065;
         6'd2:  t = 30'd34920769;
         6'd3:  t = 30'd52407779;
         6'd4:  t = 30'd69926812;
         6'd5:  t = 30'd87488664;
         6'd6:  t = 30'd105104235;
         6'd7:  t = 30'd122784561;
         6'd8:  t = 30'd140540835;
         6'd9:  t = 30'd158384440;
         6'd10: t = 30'd176326981;
         6'd11: t = 30'd194380309;
         6'd12: t = 30'd212556562;
         6'd13: t = 30'd230868191;
         6'd14: t = 30'd249328003;
         6'd15: t = 30'd267949192;
         6'd16: t = 30'd286745386;
         6'd17: t = 30'd305730681;
         6'd18: t = 30'd324919696;
         6'd19: t = 30'd344327613;
         6'd20: t = 30'd363970234;
         6'd21: t = 30'd383864035;
         6'd22: t = 30'd404026226;
         6'd23: t = 30'd424474816;
         6'd24: t = 30'd445228685;
         6'd25: t = 30'd466307658;
         6'd26: t = 30'd487732589;
         6'd27: t = 30'd509525449;
         6'd28: t = 30'd531709432;
         6'd29: t = 30'd554309051;
         6'd30: t = 30'd577350269;
         6'd31: t = 30'd600860619;
         6'd32: t = 30'd624869352;
         6'd33: t = 30'd649407593;
         6'd34: t = 30'd674508517;
         6'd35: t = 30'd700207538;
         6'd36: t = 30'd726542528;
         6'd37: t = 30'd753554050;
         6'd38: t = 30'd781285627;
         6'd39: t = 30'd809784033;
         6'd40: t = 30'd839099631;
         6'd41: t = 30'd869286738;
         6'd42: t = 30'd900404044;
         6'd43: t = 30'd932515086;
         6'd44: t = 30'd965688775;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

### rtl/sas_atan_serial.sv
`include "stick_angle_spinner_core_macros.svh"

// Truncated atan2 in degrees plus 179. The octant floor is found by a
// bit-by-bit search over k; each probe checks q*tan(k) < p bit-serially,
// LSB first, through a narrow signed accumulator.
module sas_atan_serial import sas_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sas_ang_req_type ang_req,
   output sas_ang_rsp_type ang_rsp
);

   typedef enum logic [1:0] {ANG_IDLE, ANG_SCAN, ANG_FINISH} ang_state_type;

   localparam int unsigned ACC_W = 10;
   localparam logic [4:0] CYC_LAST = 5'(TAN_W - 1);

   ang_state_type            state_ff, state_in;
   logic [6:0]               a_ff, a_in, b_ff, b_in;
   logic                     xneg_ff, xneg_in, yneg_ff, yneg_in;
   logic [5:0]               n_ff, n_in;
   logic [2:0]               bit_ff, bit_in;
   logic [4:0]               cyc_ff, cyc_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     done_ff, done_in;
   logic [8:0]               angle_ff, angle_in;

   logic [6:0]               p, q;
   logic [5:0]               cand;
   logic                     cand_ok;
   logic [TAN_W-1:0]         tan_word;
   logic                     tbit, ebit;
   logic signed [ACC_W-1:0]  sum;
   logic [6:0]               fl;
   logic                     exact;
   logic [7:0]               mag;

   assign ang_rsp.done  = done_ff;
   assign ang_rsp.angle = angle_ff;

   assign p        = (a_ff > b_ff) ? b_ff : a_ff;
   assign q        = (a_ff > b_ff) ? a_ff : b_ff;
   assign cand     = n_ff | (6'd1 << bit_ff);
   assign cand_ok  = (cand <= TAN_LAST);
   assign tan_word = tan_e9(cand);
   assign tbit     = tan_word[cyc_ff];
   assign ebit     = TAN_ONE[cyc_ff];
   assign sum      = acc_ff + $signed({3'b0, (tbit ? q : 7'd0)})
                            - $signed({3'b0, (ebit ? p : 7'd0)});

   // fold the octant floor back to the full circle
   always_comb begin
      if (a_ff <= b_ff) begin
         fl    = {1'b0, n_ff};
         exact = (a_ff == 7'd0) || (a_ff == b_ff);
      end else begin
         fl    = DEG_90 - {1'b0, n_ff} - {6'b0, (b_ff != 7'd0)};
         exact = (b_ff == 7'd0);
      end
      if (xneg_ff) begin
         mag = DEG_180 - {1'b0, fl} - {7'b0, ~exact};
      end else begin
         mag = {1'b0, fl};
      end
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      xneg_in  = xneg_ff;
      yneg_in  = yneg_ff;
      n_in     = n_ff;
      bit_in   = bit_ff;
      cyc_in   = cyc_ff;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      angle_in = angle_ff;
      unique case (state_ff)
         ANG_IDLE: begin
            if (ang_req.start) begin
               a_in     = ang_req.y[7] ? 7'(-ang_req.y) : ang_req.y[6:0];
               b_in     = ang_req.x[7] ? 7'(-ang_req.x) : ang_req.x[6:0];
               yneg_in  = ang_req.y[7];
               xneg_in  = ang_req.x[7];
               n_in     = '0;
               bit_in   = 3'd5;
               cyc_in   = '0;
               acc_in   = '0;
               state_in = ANG_SCAN;
            end
         end
         ANG_SCAN: begin
            priority if (q == 7'd0) begin
               state_in = ANG_FINISH;
            end else if (p == q) begin
               n_in     = OCT_EQUAL;
               state_in = ANG_FINISH;
            end else if (!cand_ok || cyc_ff == CYC_LAST) begin
               // probe done: q*tan(k) - p*1e9 < 0 means k is below the angle
               if (cand_ok && sum < 0) begin
                  n_in = cand;
               end
               acc_in = '0;
               cyc_in = '0;
               if (bit_ff == 3'd0) begin
                  state_in = ANG_FINISH;
               end else begin
                  bit_in = bit_ff - 3'd1;
               end
            end else begin
               acc_in = sum >>> 1;
               cyc_in = cyc_ff + 5'd1;
            end
         end
         ANG_FINISH: begin
            angle_in = yneg_ff ? (ANG_OFFSET - {1'b0, mag}) : (ANG_OFFSET + {1'b0, mag});
            done_in  = 1'b1;
            state_in = ANG_IDLE;
         end
         default: state_in = ANG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ANG_IDLE;
         done_ff  <= 1'b0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         acc_ff   <= acc_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      xneg_ff  <= xneg_in;
      yneg_ff  <= yneg_in;
      n_ff     <= n_in;
      bit_ff   <= bit_in;
      cyc_ff   <= cyc_in;
      angle_ff <= angle_in;
   end

   `SAS_ASSERT_NOW(a_start_idle, clock, reset, ang_req.start, state_ff == ANG_IDLE, "start while busy")
   `SAS_ASSERT_NOW(a_acc_range, clock, reset, state_ff == ANG_SCAN, (acc_ff <= 127) && (acc_ff >= -127), "accumulator out of range")
   `SAS_ASSERT_NOW(a_angle_range, clock, reset, done_ff, angle_ff <= ANG_MAX, "angle above 359")

endmodule

### rtl/stick_angle_spinner_core.sv
`include "stick_angle_spinner_core_macros.svh"

// channel  | handshake             | payload
// ---------+-----------------------+---------------------------------------------
// req      | req_valid / req_ready | req_pad_valid, req_left_x .. req_right_y
// rsp      | rsp_valid / rsp_ready | rsp_*_byte, rsp_spinner, rsp_spinner_moved
// csr      | csr_we (no wait)      | csr_index, csr_wdata
//
// One request at a time; req_ready is high only while the core is idle.
// Centered stick: the angle unit is skipped and the check state goes straight to emit.
// Deflected stick: the serial angle unit runs up to 6 probes over the tangent bits,
// ending early when the stick sits at center or exactly on a diagonal.
// An invalid report is accepted while idle and gives no response.
// A response held by rsp_ready low stalls the next request only at its output step.
// Reset is synchronous and restores the zone and step registers to their defaults.
module stick_angle_spinner_core import sas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_pad_valid,
   input  logic [15:0] req_left_x,
   input  logic [15:0] req_left_y,
   input  logic [15:0] req_right_x,
   input  logic [15:0] req_right_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_left_x_byte,
   output logic [7:0]  rsp_left_y_byte,
   output logic [7:0]  rsp_right_x_byte,
   output logic [7:0]  rsp_right_y_byte,
   output logic [7:0]  rsp_spinner,
   output logic        rsp_spinner_moved,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_ANGLE, ST_UPDATE, ST_EMIT} st_type;

   localparam logic signed [10:0] SPIN_TOP = 11'sd255;
   localparam logic signed [10:0] SPIN_ADD = 11'sd256;

   st_type      state_ff, state_in;
   logic [7:0]  zone_low_ff, zone_low_in, zone_high_ff, zone_high_in;
   logic [6:0]  max_step_ff, max_step_in;
   logic [7:0]  spinner_ff, spinner_in;
   logic [8:0]  prev_angle_ff, prev_angle_in;
   logic [7:0]  lx_ff, lx_in, ly_ff, ly_in, rx_ff, rx_in, ry_ff, ry_in;
   logic        moved_ff, moved_in;
   logic [8:0]  angle_ff, angle_in;
   logic        start_ff, start_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_lx_ff, rsp_lx_in, rsp_ly_ff, rsp_ly_in;
   logic [7:0]  rsp_rx_ff, rsp_rx_in, rsp_ry_ff, rsp_ry_in;
   logic [7:0]  rsp_spin_ff, rsp_spin_in;
   logic        rsp_moved_ff, rsp_moved_in;

   sas_ang_req_type ang_req;
   sas_ang_rsp_type ang_rsp;

   logic               deflected;
   logic signed [10:0] diff, lim, step, spin_next;

   function automatic logic [7:0] axis_byte(logic [15:0] raw);
      return {~raw[15], raw[14:8]} + {7'b0, raw[15]};
   endfunction

   sas_atan_serial u_atan (
      .clock   (clock),
      .reset   (reset),
      .ang_req (ang_req),
      .ang_rsp (ang_rsp)
   );

   assign ang_req.start = start_ff;
   assign ang_req.x     = $signed(rx_ff ^ BYTE_CENTRE);
   assign ang_req.y     = $signed(ry_ff ^ BYTE_CENTRE);

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_x_byte   = rsp_lx_ff;
   assign rsp_left_y_byte   = rsp_ly_ff;
   assign rsp_right_x_byte  = rsp_rx_ff;
   assign rsp_right_y_byte  = rsp_ry_ff;
   assign rsp_spinner       = rsp_spin_ff;
   assign rsp_spinner_moved = rsp_moved_ff;

   assign deflected = (rx_ff < zone_low_ff) || (rx_ff > zone_high_ff) ||
                      (ry_ff < zone_low_ff) || (ry_ff > zone_high_ff);

   // angle delta, clamped, then the spinner wrap (255 off the top, 256 onto the bottom)
   always_comb begin
      diff = $signed({2'b0, angle_ff}) - $signed({2'b0, prev_angle_ff});
      lim  = $signed({4'b0, max_step_ff});
      priority if (diff > lim) begin
         step = lim;
      end else if (diff < -lim) begin
         step = -lim;
      end else begin
         step = diff;
      end
      spin_next = $signed({3'b0, spinner_ff}) - step;
      priority if (spin_next > SPIN_TOP) begin
         spin_next = spin_next - SPIN_TOP;
      end else if (spin_next < 0) begin
         spin_next = spin_next + SPIN_ADD;
      end else begin
         spin_next = spin_next;
      end
   end

   always_comb begin
      state_in      = state_ff;
      zone_low_in   = zone_low_ff;
      zone_high_in  = zone_high_ff;
      max_step_in   = max_step_ff;
      spinner_in    = spinner_ff;
      prev_angle_in = prev_angle_ff;
      lx_in         = lx_ff;
      ly_in         = ly_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      moved_in      = moved_ff;
      angle_in      = angle_ff;
      start_in      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_lx_in     = rsp_lx_ff;
      rsp_ly_in     = rsp_ly_ff;
      rsp_rx_in     = rsp_rx_ff;
      rsp_ry_in     = rsp_ry_ff;
      rsp_spin_in   = rsp_spin_ff;
      rsp_moved_in  = rsp_moved_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ZONE_LOW:  zone_low_in  = csr_wdata;
            CSR_ZONE_HIGH: zone_high_in = csr_wdata;
            CSR_MAX_STEP:  max_step_in  = csr_wdata[6:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_pad_valid) begin
               lx_in    = axis_byte(req_left_x);
               ly_in    = axis_byte(req_left_y);
               rx_in    = axis_byte(req_right_x);
               ry_in    = axis_byte(req_right_y);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (deflected) begin
               start_in = 1'b1;
               state_in = ST_ANGLE;
            end else begin
               moved_in = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_ANGLE: begin
            if (ang_rsp.done) begin
               angle_in = ang_rsp.angle;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            spinner_in    = spin_next[7:0];
            prev_angle_in = angle_ff;
            moved_in      = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_lx_in    = lx_ff;
               rsp_ly_in    = ly_ff;
               rsp_rx_in    = rx_ff;
               rsp_ry_in    = ry_ff;
               rsp_spin_in  = spinner_ff;
               rsp_moved_in = moved_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         zone_low_ff   <= ZONE_LOW_RST;
         zone_high_ff  <= ZONE_HIGH_RST;
         max_step_ff   <= MAX_STEP_RST;
         spinner_ff    <= '0;
         prev_angle_ff <= '0;
         start_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         zone_low_ff   <= zone_low_in;
         zone_high_ff  <= zone_high_in;
         max_step_ff   <= max_step_in;
         spinner_ff    <= spinner_in;
         prev_angle_ff <= prev_angle_in;
         start_ff      <= start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lx_ff        <= lx_in;
      ly_ff        <= ly_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      moved_ff     <= moved_in;
      angle_ff     <= angle_in;
      rsp_lx_ff    <= rsp_lx_in;
      rsp_ly_ff    <= rsp_ly_in;
      rsp_rx_ff    <= rsp_rx_in;
      rsp_ry_ff    <= rsp_ry_in;
      rsp_spin_ff  <= rsp_spin_in;
      rsp_moved_ff <= rsp_moved_in;
   end

   `SAS_ASSERT_NEXT(a_spin_hold, clock, reset, state_ff != ST_UPDATE, $stable(spinner_ff) && $stable(prev_angle_ff), "spinner moved outside update")
   `SAS_ASSERT_NOW(a_done_in_angle, clock, reset, ang_rsp.done, state_ff == ST_ANGLE, "angle done while not waiting")
   `SAS_ASSERT_NOW(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_EMIT), "response loaded outside emit")
   `SAS_ASSERT_NOW(a_prev_range, clock, reset, state_ff == ST_UPDATE, angle_ff <= ANG_MAX, "angle out of range")

endmodule
